// ----- sv/fla_pkg.sv -----
package fla_pkg;

  // Cell command broadcast along the extent row
  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_INIT   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_INSERT = 3'd3,
    OP_REMOVE = 3'd4,
    OP_MERGE  = 3'd5
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOSPACE   = 3'd1,
    ST_OUTSIDE   = 3'd2,
    ST_OVL_PRIOR = 3'd3,
    ST_OVL_NEXT  = 3'd4,
    ST_NOTALLOC  = 3'd5,
    ST_FULL      = 3'd6
  } status_e;

  typedef enum logic [0:0] {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [0:0] {
    REG_POOL_SIZE = 1'b0,
    REG_FIT_MODE  = 1'b1
  } reg_idx_e;

  // Compare flags reported by each cell
  typedef struct packed {
    logic fit;  // valid and length covers the requested size
    logic gt;   // valid and request address lies above the base
  } cell_flag_t;

endpackage

// ----- sv/fla_req_if.sv -----
interface fla_req_if #(
  parameter int ADDR_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [ADDR_BITS:0]   req_size;
  logic [ADDR_BITS-1:0] req_addr;

  modport source (output valid, kind, req_size, req_addr, input ready);
  modport sink   (input valid, kind, req_size, req_addr, output ready);
endinterface

// ----- sv/fla_rsp_if.sv -----
interface fla_rsp_if #(
  parameter int ADDR_BITS = 20
);
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] result_addr;
  logic [2:0]           status;

  modport source (output valid, result_addr, status, input ready);
  modport sink   (input valid, result_addr, status, output ready);
endinterface

// ----- sv/fla_cell.sv -----
module fla_cell
  import fla_pkg::*;
#(
  parameter int ADDR_BITS = 20,
  parameter int CW        = 7,
  parameter int IDX       = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_op_e             op_i,
  input  logic [CW-1:0]        idx_i,
  input  logic [ADDR_BITS-1:0] wbase_i,
  input  logic [ADDR_BITS:0]   wlen_i,
  input  logic [CW-1:0]        count_i,
  input  logic [ADDR_BITS:0]   size_i,
  input  logic [ADDR_BITS-1:0] addr_i,
  input  logic [ADDR_BITS-1:0] left_base_i,
  input  logic [ADDR_BITS:0]   left_len_i,
  input  logic [ADDR_BITS-1:0] right_base_i,
  input  logic [ADDR_BITS:0]   right_len_i,
  output logic [ADDR_BITS-1:0] base_o,
  output logic [ADDR_BITS:0]   len_o,
  output cell_flag_t           flag_o
);

  localparam logic [CW-1:0]      MyIdx   = CW'(IDX);
  localparam logic [ADDR_BITS:0] LenRst  = (IDX == 0) ? (ADDR_BITS+1)'(1) << ADDR_BITS
                                                      : '0;

  logic [ADDR_BITS-1:0] base_q, base_d;
  logic [ADDR_BITS:0]   len_q, len_d;
  logic                 valid;

  assign valid = MyIdx < count_i;

  // Report compare flags for the current request
  assign flag_o.fit = valid && (len_q >= size_i);
  assign flag_o.gt  = valid && (addr_i > base_q);

  // Pick next contents: hold, write, or take a neighbor's extent
  always_comb begin
    base_d = base_q;
    len_d  = len_q;
    case (op_i)
      OP_INIT: begin
        if (IDX == 0) begin
          base_d = '0;
          len_d  = wlen_i;
        end
      end
      OP_WRITE: begin
        if (MyIdx == idx_i) begin
          base_d = wbase_i;
          len_d  = wlen_i;
        end
      end
      OP_INSERT: begin
        if (MyIdx == idx_i) begin
          base_d = wbase_i;
          len_d  = wlen_i;
        end else if (MyIdx > idx_i) begin
          base_d = left_base_i;
          len_d  = left_len_i;
        end
      end
      OP_REMOVE: begin
        if (MyIdx >= idx_i) begin
          base_d = right_base_i;
          len_d  = right_len_i;
        end
      end
      OP_MERGE: begin
        if (MyIdx == idx_i) begin
          base_d = wbase_i;
          len_d  = wlen_i;
        end else if (MyIdx > idx_i) begin
          base_d = right_base_i;
          len_d  = right_len_i;
        end
      end
      default: begin
        base_d = base_q;
        len_d  = len_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      len_q  <= LenRst;
    end else begin
      base_q <= base_d;
      len_q  <= len_d;
    end
  end

  assign base_o = base_q;
  assign len_o  = len_q;

endmodule

// ----- sv/free_list_allocator.sv -----
// Free-list allocator: keeps the free space of a pool as an address-sorted row of
// MAX_EXTENTS extent cells and serves allocate (first fit or next fit) and free
// (with coalescing) requests. A request is taken only while the sequencer is idle.
// After acceptance, all cells compare in parallel, the winning cell and its
// neighbors are picked, and then the cell row is shifted or rewritten. The
// sequencer then returns to idle before the next request is taken, so one request
// is in flight at a time. A new one is taken while the previous result still waits
// in the output register; its execute step then holds until that result is taken.
// Writing pool_size reloads the row as a single free extent, or as an empty row
// when the size is zero.
module free_list_allocator
  import fla_pkg::*;
#(
  parameter int MAX_EXTENTS = 64,
  parameter int ADDR_BITS   = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fla_req_if.sink              req,
  fla_rsp_if.source            rsp,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [ADDR_BITS:0]   cfg_data_i
);

  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int SW = ADDR_BITS + 1;
  localparam logic [SW-1:0] PoolMax = SW'(1) << ADDR_BITS;
  localparam logic [CW-1:0] CntMax  = CW'(MAX_EXTENTS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_SEL  = 4'b0100,
    S_EXEC = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [SW-1:0]        pool_q;
  logic                 fit_mode_q;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        cursor_q, cursor_d;

  logic                 kind_q;
  logic [SW-1:0]        size_q;
  logic [ADDR_BITS-1:0] addr_q;

  logic [MAX_EXTENTS-1:0] fit_q, gt_q;

  // Selection results
  logic                 found_q;
  logic [CW-1:0]        pick_q, n_q;
  logic [ADDR_BITS-1:0] sbase_q, pbase_q, nbase_q;
  logic [SW-1:0]        slen_q, plen_q, nlen_q;
  logic                 has_prior_q, has_next_q;

  logic                 out_valid_q;
  logic [ADDR_BITS-1:0] out_addr_q;
  status_e              out_status_q;

  // Cell row
  cell_op_e             op;
  logic [CW-1:0]        op_idx;
  logic [ADDR_BITS-1:0] op_base;
  logic [SW-1:0]        op_len;
  logic [ADDR_BITS-1:0] cell_base [MAX_EXTENTS];
  logic [SW-1:0]        cell_len  [MAX_EXTENTS];
  cell_flag_t           cell_flag [MAX_EXTENTS];

  for (genvar g = 0; g < MAX_EXTENTS; g++) begin : g_cell
    logic [ADDR_BITS-1:0] lb, rb;
    logic [SW-1:0]        ll, rl;
    if (g == 0) begin : g_first
      assign lb = '0;
      assign ll = '0;
    end else begin : g_left
      assign lb = cell_base[g-1];
      assign ll = cell_len[g-1];
    end
    if (g == MAX_EXTENTS - 1) begin : g_last
      assign rb = '0;
      assign rl = '0;
    end else begin : g_right
      assign rb = cell_base[g+1];
      assign rl = cell_len[g+1];
    end
    fla_cell #(
      .ADDR_BITS(ADDR_BITS),
      .CW       (CW),
      .IDX      (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op),
      .idx_i       (op_idx),
      .wbase_i     (op_base),
      .wlen_i      (op_len),
      .count_i     (count_q),
      .size_i      (size_q),
      .addr_i      (addr_q),
      .left_base_i (lb),
      .left_len_i  (ll),
      .right_base_i(rb),
      .right_len_i (rl),
      .base_o      (cell_base[g]),
      .len_o       (cell_len[g]),
      .flag_o      (cell_flag[g])
    );
  end

  assign req.ready = (state_q == S_IDLE);

  // Saturate pool size writes to the address space
  logic [SW-1:0] cfg_pool;
  assign cfg_pool = (cfg_data_i > PoolMax) ? PoolMax : cfg_data_i;

  // Pick first fitting cell (from the cursor in next-fit mode), the free insertion point and its neighbors
  logic [CW-1:0]          start;
  logic [MAX_EXTENTS-1:0] ge_mask, fit_m, pick_vec, pick_oh, next_oh, prior_oh, not_gt;
  logic [IW-1:0]          pick_enc, next_enc;
  logic [ADDR_BITS-1:0]   sel_sbase, sel_pbase, sel_nbase;
  logic [SW-1:0]          sel_slen, sel_plen, sel_nlen;
  logic [CW-1:0]          sel_n;

  assign start = (fit_mode_q && (cursor_q < count_q)) ? cursor_q : '0;

  always_comb begin
    for (int i = 0; i < MAX_EXTENTS; i++) begin
      ge_mask[i] = CW'(i) >= start;
    end
    fit_m    = fit_q & ge_mask;
    pick_vec = (fit_m != '0) ? fit_m : fit_q;
    pick_oh  = pick_vec & (~pick_vec + 1'b1);
    not_gt   = ~gt_q;
    next_oh  = not_gt & (~not_gt + 1'b1);
    prior_oh = gt_q & ~(gt_q >> 1);
    pick_enc  = '0;
    next_enc  = '0;
    sel_sbase = '0;
    sel_slen  = '0;
    sel_pbase = '0;
    sel_plen  = '0;
    sel_nbase = '0;
    sel_nlen  = '0;
    for (int i = 0; i < MAX_EXTENTS; i++) begin
      if (pick_oh[i]) begin
        pick_enc  = pick_enc | IW'(i);
        sel_sbase = sel_sbase | cell_base[i];
        sel_slen  = sel_slen | cell_len[i];
      end
      if (next_oh[i]) begin
        next_enc  = next_enc | IW'(i);
        sel_nbase = sel_nbase | cell_base[i];
        sel_nlen  = sel_nlen | cell_len[i];
      end
      if (prior_oh[i]) begin
        sel_pbase = sel_pbase | cell_base[i];
        sel_plen  = sel_plen | cell_len[i];
      end
    end
    sel_n = (not_gt != '0) ? CW'(next_enc) : CntMax;
  end

  // Decide the outcome and drive the cell row
  logic [SW:0]   req_end, prior_end;
  logic [SW:0]   merge_len;
  status_e       exec_status;
  logic [ADDR_BITS-1:0] exec_addr;

  assign req_end   = {1'b0, size_q} + {2'b0, addr_q};
  assign prior_end = {2'b0, pbase_q} + {1'b0, plen_q};

  always_comb begin
    op          = OP_HOLD;
    op_idx      = '0;
    op_base     = '0;
    op_len      = '0;
    count_d     = count_q;
    cursor_d    = cursor_q;
    exec_status = ST_OK;
    exec_addr   = '0;
    merge_len   = '0;
    if (state_q == S_IDLE) begin
      if (cfg_we_i && (cfg_idx_i == REG_POOL_SIZE)) begin
        op       = OP_INIT;
        op_len   = cfg_pool;
        count_d  = (cfg_pool != '0) ? CW'(1) : '0;
        cursor_d = '0;
      end
    end else if ((state_q == S_EXEC) && !(out_valid_q && !rsp.ready)) begin
      if (kind_q == KIND_ALLOC) begin
        if (!found_q) begin
          exec_status = ST_NOSPACE;
        end else begin
          exec_addr = sbase_q;
          cursor_d  = pick_q;
          op_idx    = pick_q;
          if (slen_q == size_q) begin
            op      = OP_REMOVE;
            count_d = count_q - 1'b1;
          end else begin
            op      = OP_WRITE;
            op_base = sbase_q + size_q[ADDR_BITS-1:0];
            op_len  = slen_q - size_q;
          end
        end
      end else begin
        if (has_next_q && (addr_q == nbase_q)) begin
          exec_status = ST_NOTALLOC;
        end else if (!has_next_q && (req_end > {1'b0, pool_q})) begin
          exec_status = ST_OUTSIDE;
        end else if (has_prior_q && ({2'b0, addr_q} < prior_end)) begin
          exec_status = ST_OVL_PRIOR;
        end else if (has_next_q && (req_end > {2'b0, nbase_q})) begin
          exec_status = ST_OVL_NEXT;
        end else if (size_q == '0) begin
          exec_status = ST_OK;
        end else if (has_prior_q && ({2'b0, addr_q} == prior_end)) begin
          op_base = pbase_q;
          op_idx  = n_q - 1'b1;
          if (has_next_q && (req_end == {2'b0, nbase_q})) begin
            merge_len = {1'b0, plen_q} + {1'b0, size_q} + {1'b0, nlen_q};
            op        = OP_MERGE;
            op_len    = merge_len[SW-1:0];
            count_d   = count_q - 1'b1;
            if (cursor_q > n_q) begin
              cursor_d = cursor_q - 1'b1;
            end
          end else begin
            op     = OP_WRITE;
            op_len = plen_q + size_q;
          end
        end else if (has_next_q && (req_end == {2'b0, nbase_q})) begin
          op      = OP_WRITE;
          op_idx  = n_q;
          op_base = addr_q;
          op_len  = nlen_q + size_q;
        end else if (count_q >= CntMax) begin
          exec_status = ST_FULL;
        end else begin
          op      = OP_INSERT;
          op_idx  = n_q;
          op_base = addr_q;
          op_len  = size_q;
          count_d = count_q + 1'b1;
          if (cursor_q >= n_q) begin
            cursor_d = cursor_q + 1'b1;
          end
        end
      end
    end
  end

  // Advance the request sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req.valid) state_d = S_CMP;
      end
      S_CMP:  state_d = S_SEL;
      S_SEL:  state_d = S_EXEC;
      S_EXEC: begin
        if (!(out_valid_q && !rsp.ready)) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pool_q      <= PoolMax;
      fit_mode_q  <= 1'b0;
      count_q     <= CW'(1);
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      if (state_q == S_IDLE && cfg_we_i) begin
        if (cfg_idx_i == REG_POOL_SIZE) pool_q <= cfg_pool;
        else fit_mode_q <= cfg_data_i[0];
      end
      if (state_q == S_EXEC && state_d == S_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Latch request, flags, selections and result
  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      kind_q <= req.kind;
      size_q <= req.req_size;
      addr_q <= req.req_addr;
    end
    if (state_q == S_CMP) begin
      for (int i = 0; i < MAX_EXTENTS; i++) begin
        fit_q[i] <= cell_flag[i].fit;
        gt_q[i]  <= cell_flag[i].gt;
      end
    end
    if (state_q == S_SEL) begin
      found_q     <= fit_q != '0;
      pick_q      <= CW'(pick_enc);
      sbase_q     <= sel_sbase;
      slen_q      <= sel_slen;
      pbase_q     <= sel_pbase;
      plen_q      <= sel_plen;
      nbase_q     <= sel_nbase;
      nlen_q      <= sel_nlen;
      n_q         <= sel_n;
      has_prior_q <= gt_q[0];
      has_next_q  <= sel_n < count_q;
    end
    if (state_q == S_EXEC && state_d == S_IDLE) begin
      out_addr_q   <= exec_addr;
      out_status_q <= exec_status;
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.result_addr = out_addr_q;
  assign rsp.status      = out_status_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax) else $error("extent count above table size");
  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= count_q) else $error("cursor beyond extent count");
  a_rsp_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EXEC)) else $error("result without execution");
`endif

endmodule
